[src/vlsm_pkg.sv]
package vlsm_pkg;

  // Quotient bits, one division cell per bit.
  localparam int unsigned NUM_CELLS = 8;
  localparam int unsigned REM_W     = 25;
  localparam int unsigned DVS_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_MODE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_ONE_LINES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X_START  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X_END    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y_START  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y_END    = 3'd7;

  localparam logic [1:0] MASK_OFF        = 2'd0;
  localparam logic [1:0] MASK_INTERLACED = 2'd1;
  localparam logic [1:0] MASK_SEQUENTIAL = 2'd2;

  localparam logic [7:0] GREY_MAX = 8'd255;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [9:0]         pix_row;
    logic [10:0]        column;
  } in_t;

  typedef struct packed {
    logic [7:0] grey;
    logic       outside_window;
  } out_t;

  typedef struct packed {
    logic signed [15:0] low_level;
    logic signed [15:0] high_level;
    logic [1:0]         mask_mode;
    logic [9:0]         field_one_lines;
    logic [10:0]        window_x_start;
    logic [10:0]        window_x_end;
    logic [9:0]         window_y_start;
    logic [9:0]         window_y_end;
  } cfg_t;

  // Two's complement differences after the first stage.
  typedef struct packed {
    logic [16:0] diff;
    logic [16:0] span;
    logic        outside;
  } front_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [DVS_W-1:0]     dvs;
    logic [NUM_CELLS-1:0] quo;
    logic                 force_zero;
    logic                 force_max;
    logic                 outside;
  } cell_t;

  // grey*3/10 as grey*615 >> 11, exact for every 8-bit grey value.
  function automatic logic [7:0] dim_grey(input logic [7:0] g);
    logic [17:0] prod;
    prod = {10'd0, g} * 18'd615;
    return {1'b0, prod[17:11]};
  endfunction

endpackage

[src/video_level_scale_and_mask.sv]
// Scales one signed video sample to an 8-bit grey value and dims pixels that
// lie outside the active picture window when masking is on.
// The input channel (in_valid, in_ready, in_data) carries sample, display row
// and column; the result channel (out_valid, out_ready, out_data) carries grey
// and the outside_window flag, one result per input, in order.
// Eight configuration registers are written through cfg_wr_en, cfg_index and
// cfg_data; write them only while no transfer is in flight.
// The path holds eleven stages: one for the level differences and window
// test, one for the scaled numerator and the saturation check, eight
// division cells that each settle one quotient bit, and the output register
// with the dimming. Throughput is one item per cycle while out_ready is high;
// each stage holds its item and passes it on whenever the stage after it is
// empty or moving.
// Synchronous reset empties the pipeline and loads the register defaults.
// When out_ready is low the pipeline keeps filling its empty stages; in_ready
// falls only when every stage holds an item.
module video_level_scale_and_mask (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  vlsm_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output vlsm_pkg::out_t                      out_data,
  input  logic                                cfg_wr_en,
  input  logic [vlsm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vlsm_pkg::CFG_DAT_W-1:0]      cfg_data
);

  vlsm_pkg::cfg_t   cfg_r;
  vlsm_pkg::front_t front_data;
  logic             front_valid;
  logic             front_ready;
  vlsm_pkg::cell_t  chain_data  [0:vlsm_pkg::NUM_CELLS];
  logic             chain_valid [0:vlsm_pkg::NUM_CELLS];
  logic             chain_ready [0:vlsm_pkg::NUM_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_level       <= 16'sd0;
      cfg_r.high_level      <= 16'sd1023;
      cfg_r.mask_mode       <= vlsm_pkg::MASK_OFF;
      cfg_r.field_one_lines <= 10'd313;
      cfg_r.window_x_start  <= '0;
      cfg_r.window_x_end    <= '0;
      cfg_r.window_y_start  <= '0;
      cfg_r.window_y_end    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        vlsm_pkg::CFG_LOW_LEVEL:       cfg_r.low_level       <= cfg_data;
        vlsm_pkg::CFG_HIGH_LEVEL:      cfg_r.high_level      <= cfg_data;
        vlsm_pkg::CFG_MASK_MODE:       cfg_r.mask_mode       <= cfg_data[1:0];
        vlsm_pkg::CFG_FIELD_ONE_LINES: cfg_r.field_one_lines <= cfg_data[9:0];
        vlsm_pkg::CFG_WINDOW_X_START:  cfg_r.window_x_start  <= cfg_data[10:0];
        vlsm_pkg::CFG_WINDOW_X_END:    cfg_r.window_x_end    <= cfg_data[10:0];
        vlsm_pkg::CFG_WINDOW_Y_START:  cfg_r.window_y_start  <= cfg_data[9:0];
        vlsm_pkg::CFG_WINDOW_Y_END:    cfg_r.window_y_end    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  vlsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_valid),
    .up_data  (in_data),
    .up_ready (in_ready),
    .dn_valid (front_valid),
    .dn_data  (front_data),
    .dn_ready (front_ready)
  );

  vlsm_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_data  (front_data),
    .up_ready (front_ready),
    .dn_valid (chain_valid[0]),
    .dn_data  (chain_data[0]),
    .dn_ready (chain_ready[0])
  );

  for (genvar i = 0; i < vlsm_pkg::NUM_CELLS; i++) begin : g_cell
    vlsm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_data  (chain_data[i]),
      .up_ready (chain_ready[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_data  (chain_data[i+1]),
      .dn_ready (chain_ready[i+1])
    );
  end

  vlsm_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[vlsm_pkg::NUM_CELLS]),
    .up_data  (chain_data[vlsm_pkg::NUM_CELLS]),
    .up_ready (chain_ready[vlsm_pkg::NUM_CELLS]),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (out_ready)
  );

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the pipeline has room");

  a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside_window |-> out_data.grey <= 8'd76)
    else $error("dimmed grey above 3/10 of full scale");

  a_dim_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside_window |->
      (cfg_r.mask_mode == vlsm_pkg::MASK_INTERLACED) ||
      (cfg_r.mask_mode == vlsm_pkg::MASK_SEQUENTIAL))
    else $error("pixel dimmed with masking off");

endmodule

[src/vlsm_front.sv]
module vlsm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  vlsm_pkg::cfg_t   cfg,
  input  logic             up_valid,
  input  vlsm_pkg::in_t    up_data,
  output logic             up_ready,
  output logic             dn_valid,
  output vlsm_pkg::front_t dn_data,
  input  logic             dn_ready
);

  logic             valid_r;
  vlsm_pkg::front_t data_r;
  vlsm_pkg::front_t data_nxt;
  logic [10:0]      weaved;
  logic             mask_on;
  logic             win_empty;
  logic             y_out;
  logic             x_out;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    mask_on = (cfg.mask_mode == vlsm_pkg::MASK_INTERLACED) ||
              (cfg.mask_mode == vlsm_pkg::MASK_SEQUENTIAL);
    win_empty = (cfg.window_x_end <= cfg.window_x_start) ||
                (cfg.window_y_end <= cfg.window_y_start);
    if (cfg.mask_mode == vlsm_pkg::MASK_INTERLACED) begin
      weaved = {1'b0, up_data.pix_row};
    end else if (up_data.pix_row < cfg.field_one_lines) begin
      weaved = {up_data.pix_row, 1'b0};
    end else begin
      weaved = {up_data.pix_row - cfg.field_one_lines, 1'b1};
    end
    y_out = (weaved < {1'b0, cfg.window_y_start}) || (weaved >= {1'b0, cfg.window_y_end});
    x_out = (up_data.column < cfg.window_x_start) || (up_data.column >= cfg.window_x_end);
    data_nxt.outside = mask_on && !win_empty && (y_out || x_out);
    data_nxt.diff = {up_data.sample[15], up_data.sample} -
                    {cfg.low_level[15], cfg.low_level};
    data_nxt.span = {cfg.high_level[15], cfg.high_level} -
                    {cfg.low_level[15], cfg.low_level};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[src/vlsm_prep.sv]
module vlsm_prep (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  vlsm_pkg::front_t up_data,
  output logic             up_ready,
  output logic             dn_valid,
  output vlsm_pkg::cell_t  dn_data,
  input  logic             dn_ready
);

  logic                          valid_r;
  vlsm_pkg::cell_t               data_r;
  vlsm_pkg::cell_t               data_nxt;
  logic [24:0]                   num;
  logic                          span_pos;
  logic [vlsm_pkg::DVS_W-1:0]    dvs;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    // diff * 255 as diff * 256 - diff; fits 25 bits signed.
    num      = {up_data.diff, 8'd0} - {{8{up_data.diff[16]}}, up_data.diff};
    span_pos = !up_data.span[16] && (up_data.span != 17'd0);
    dvs      = {up_data.span[15:0], 8'd0};
    data_nxt.force_zero = !span_pos || num[24];
    data_nxt.force_max  = span_pos && !num[24] && (num[23:0] >= dvs);
    // Pre-shifted so that the first cell decides the top quotient bit.
    data_nxt.rem     = {num[23:0], 1'b0};
    data_nxt.dvs     = dvs;
    data_nxt.quo     = '0;
    data_nxt.outside = up_data.outside;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

[src/vlsm_div_cell.sv]
module vlsm_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  vlsm_pkg::cell_t up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output vlsm_pkg::cell_t dn_data,
  input  logic            dn_ready
);

  logic                       valid_r;
  vlsm_pkg::cell_t            data_r;
  vlsm_pkg::cell_t            data_nxt;
  logic [vlsm_pkg::REM_W-1:0] sub;
  logic                       take;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // One restoring division step against the divisor scaled by 256.
  always_comb begin
    take     = up_data.rem >= {1'b0, up_data.dvs};
    sub      = up_data.rem - {1'b0, up_data.dvs};
    data_nxt = up_data;
    if (take) begin
      data_nxt.rem = {sub[vlsm_pkg::REM_W-2:0], 1'b0};
    end else begin
      data_nxt.rem = {up_data.rem[vlsm_pkg::REM_W-2:0], 1'b0};
    end
    data_nxt.quo = {up_data.quo[vlsm_pkg::NUM_CELLS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.force_zero && !data_r.force_max |->
      data_r.rem < {data_r.dvs, 1'b0})
    else $error("division remainder out of bound");

endmodule

[src/vlsm_out.sv]
module vlsm_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  vlsm_pkg::cell_t up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output vlsm_pkg::out_t  dn_data,
  input  logic            dn_ready
);

  logic           valid_r;
  vlsm_pkg::out_t data_r;
  vlsm_pkg::out_t data_nxt;
  logic [7:0]     grey;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    if (up_data.force_zero) begin
      grey = '0;
    end else if (up_data.force_max) begin
      grey = vlsm_pkg::GREY_MAX;
    end else begin
      grey = up_data.quo;
    end
    data_nxt.outside_window = up_data.outside;
    data_nxt.grey = up_data.outside ? vlsm_pkg::dim_grey(grey) : grey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
